// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation unit.
// Standalone; used by all modules in rtl/core.
package mexp_pkg;

  localparam int MOD_W     = 32;
  localparam int EXP_MAX_W = 64;
  localparam int EXP_BITS_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MOD_W-1:0] MOD_RESET = 32'd65537;

  // Request class, decided at the front
  localparam logic [1:0] CLS_ONE  = 2'd0;  // exponent zero
  localparam logic [1:0] CLS_ZERO = 2'd1;  // modulus zero, nonzero exponent
  localparam logic [1:0] CLS_RUN  = 2'd2;  // full square-and-multiply

  localparam logic KIND_POWER   = 1'b0;
  localparam logic KIND_INVERSE = 1'b1;

  typedef struct packed {
    logic [1:0]           cls;
    logic [MOD_W-1:0]     base;
    logic [MOD_W-1:0]     modulus;
    logic [EXP_MAX_W-1:0] exponent;
  } mexp_item_t;

endpackage

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit.
// Depends on mexp_pkg, mexp_front, mexp_queue and mexp_back.
//
// Computes base ^ e mod modulus by left-to-right square-and-multiply. A
// request is taken at a clock edge with start high and busy low; kind 0
// uses in_exponent as e, kind 1 uses modulus - 2 (the Fermat inverse for a
// prime modulus), and e keeps its low EXP_BITS bits. A zero exponent gives
// 1; a zero modulus gives 0 for any other exponent. The modulus is written
// through the cfg_ channel (reset value 65537) and is captured with each
// request, so write it only while no request is pending. Each result shows
// on out_result for exactly one cycle with out_valid high; the receiver
// cannot stall it, so take it on that cycle. The queue holds up to two
// requests, so busy drops again while the back end works. A request that
// finds the back end idle is popped at the edge after it is taken. After
// the pop, an exponent of zero or a zero modulus is answered directly;
// otherwise the back end drops the leading zero bits of e, finds the top
// bit, then squares for each bit and multiplies for each one bit, each
// product from the multiplier reduced by the two-bit-per-cycle remainder
// unit, and registers the result on out_result.
module modular_exponentiation_unit #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: modulus
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0]     cfg_data,
  // request
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [mexp_pkg::MOD_W-1:0]     in_base,
  input  logic [mexp_pkg::EXP_MAX_W-1:0] in_exponent,
  // result
  output logic                           out_valid,
  output logic [mexp_pkg::MOD_W-1:0]     out_result
);

  mexp_pkg::mexp_item_t push_item;
  mexp_pkg::mexp_item_t head_item;
  logic push;
  logic pop;
  logic queue_empty;
  logic queue_full;

  // Hold off new requests only while the queue is full
  assign busy = queue_full;

  mexp_front #(
    .EXP_BITS (EXP_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .start       (start),
    .in_kind     (in_kind),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  mexp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  mexp_back #(
    .EXP_BITS (EXP_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

endmodule

// ===== rtl/core/mexp_front.sv =====
// Front end: modulus register, request acceptance and classification.
// Depends on mexp_pkg.
module mexp_front #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_data,
  input  logic                      start,
  input  logic                      in_kind,
  input  logic [mexp_pkg::MOD_W-1:0] in_base,
  input  logic [mexp_pkg::EXP_MAX_W-1:0] in_exponent,
  input  logic                      queue_full,
  output logic                      push,
  output mexp_pkg::mexp_item_t      push_item
);

  localparam int XW = mexp_pkg::EXP_MAX_W;

  logic [mexp_pkg::MOD_W-1:0] modulus_r, modulus_nxt;
  logic [XW-1:0]              exp_full;
  logic [EXP_BITS-1:0]        exp_masked;

  assign cfg_ready = 1'b1;

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_valid) begin
      modulus_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MOD_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  // Inverse exponent wraps below two, as a 64-bit subtraction
  always_comb begin
    if (in_kind == mexp_pkg::KIND_INVERSE) begin
      exp_full = XW'(modulus_r) - XW'(2);
    end else begin
      exp_full = in_exponent;
    end
    exp_masked = exp_full[EXP_BITS-1:0];
  end

  assign push = start && !queue_full;

  always_comb begin
    push_item.base     = in_base;
    push_item.modulus  = modulus_r;
    push_item.exponent = XW'(exp_masked);
    if (exp_masked == '0) begin
      push_item.cls = mexp_pkg::CLS_ONE;
    end else if (modulus_r == '0) begin
      push_item.cls = mexp_pkg::CLS_ZERO;
    end else begin
      push_item.cls = mexp_pkg::CLS_RUN;
    end
  end

endmodule

// ===== rtl/core/mexp_queue.sv =====
// Short request queue between front and back end.
// Depends on mexp_pkg.
module mexp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mexp_pkg::mexp_item_t push_item,
  input  logic                 pop,
  output mexp_pkg::mexp_item_t head_item,
  output logic                 empty,
  output logic                 full
);

  localparam int DEPTH = mexp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mexp_pkg::mexp_item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/mexp_back.sv =====
// Back end: square-and-multiply sequencer with a 32x32 multiplier and a
// two-bit-per-cycle remainder unit. Depends on mexp_pkg.
module mexp_back #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       queue_empty,
  input  mexp_pkg::mexp_item_t       head_item,
  output logic                       pop,
  output logic                       out_valid,
  output logic [mexp_pkg::MOD_W-1:0] out_result
);

  localparam int MW     = mexp_pkg::MOD_W;
  localparam int PW     = 2 * MW;
  localparam int RED_N  = PW / 2;
  localparam int RCW    = $clog2(RED_N);
  localparam int CNTW   = $clog2(EXP_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_RED  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [MW-1:0]       acc_r, acc_nxt;
  logic [MW-1:0]       base_r, base_nxt;
  logic [MW-1:0]       mod_r, mod_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic                mul_phase_r, mul_phase_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [MW-1:0]       rem_r, rem_nxt;
  logic [RCW-1:0]      red_cnt_r, red_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MW-1:0]       out_result_r, out_result_nxt;

  logic [MW-1:0]       mul_b;
  logic [PW-1:0]       prod_w;
  logic [MW-1:0]       rem_mid, rem_step;

  // One restoring step: shift in a bit, subtract the modulus if it fits
  function automatic logic [MW-1:0] red_step(input logic [MW-1:0] rem,
                                             input logic in_bit,
                                             input logic [MW-1:0] m);
    logic [MW:0] t;
    logic [MW:0] d;
    t = {rem, in_bit};
    d = t - {1'b0, m};
    return (t >= {1'b0, m}) ? d[MW-1:0] : t[MW-1:0];
  endfunction

  assign mul_b    = mul_phase_r ? base_r : acc_r;
  assign prod_w   = acc_r * mul_b;
  assign rem_mid  = red_step(rem_r, prod_r[PW-1], mod_r);
  assign rem_step = red_step(rem_mid, prod_r[PW-2], mod_r);

  assign pop        = (state_r == ST_IDLE) && !queue_empty;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    mod_nxt        = mod_r;
    exp_nxt        = exp_r;
    cnt_nxt        = cnt_r;
    mul_phase_nxt  = mul_phase_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    red_cnt_nxt    = red_cnt_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    case (state_r)
      ST_IDLE: begin
        if (!queue_empty) begin
          base_nxt = head_item.base;
          mod_nxt  = head_item.modulus;
          exp_nxt  = head_item.exponent[EXP_BITS-1:0];
          cnt_nxt  = CNTW'(EXP_BITS);
          acc_nxt  = MW'(1);
          case (head_item.cls)
            mexp_pkg::CLS_ONE: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = MW'(1);
            end
            mexp_pkg::CLS_ZERO: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = '0;
            end
            default: begin
              state_nxt = ST_SKIP;
            end
          endcase
        end
      end

      // Drop leading zero bits: the accumulator stays at one across them
      ST_SKIP: begin
        if (exp_r[EXP_BITS-1]) begin
          mul_phase_nxt = 1'b0;
          state_nxt     = ST_MUL;
        end else begin
          exp_nxt = exp_r << 1;
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end

      ST_MUL: begin
        prod_nxt    = prod_w;
        rem_nxt     = '0;
        red_cnt_nxt = RCW'(RED_N - 1);
        state_nxt   = ST_RED;
      end

      ST_RED: begin
        rem_nxt  = rem_step;
        prod_nxt = prod_r << 2;
        if (red_cnt_r != '0) begin
          red_cnt_nxt = red_cnt_r - RCW'(1);
        end else begin
          acc_nxt = rem_step;
          if (!mul_phase_r && exp_r[EXP_BITS-1]) begin
            mul_phase_nxt = 1'b1;
            state_nxt     = ST_MUL;
          end else begin
            exp_nxt       = exp_r << 1;
            cnt_nxt       = cnt_r - CNTW'(1);
            mul_phase_nxt = 1'b0;
            if (cnt_r == CNTW'(1)) begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = rem_step;
              state_nxt      = ST_IDLE;
            end else begin
              state_nxt = ST_MUL;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    mod_r        <= mod_nxt;
    exp_r        <= exp_nxt;
    cnt_r        <= cnt_nxt;
    mul_phase_r  <= mul_phase_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    red_cnt_r    <= red_cnt_nxt;
    out_result_r <= out_result_nxt;
  end

endmodule

// ===== sim/modular_exponentiation_unit_test.sv =====
// Self-checking testbench for modular_exponentiation_unit: power and inverse requests
// under several modulus settings, with results checked against an in-bench predictor.
// Depends on mexp_pkg and the RTL in rtl/core; needs nothing else.
module modular_exponentiation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  // Width of the exponent register in the instance under test
  localparam int EXP_W = EXP_BITS_DEFAULT;
  // Worst-case request time, plus margin: the pop, then a squaring and a
  // multiply for every bit of the exponent register
  localparam int DRAIN_CYCLES = 1 + 66 * EXP_W + 100;
  // Number of random requests per phase
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    logic                 kind;
    logic [MOD_W-1:0]     base;
    logic [EXP_MAX_W-1:0] exponent;
  } exp_request_t;

  // Predict base ^ e mod modulus for each accepted request, and check the results
  // in arrival order.
  class modpow_scoreboard;
    bit [MOD_W-1:0] expected_powers[$];
    int unsigned mismatches;
    int unsigned requests_noted;
    int unsigned inverses_noted;
    int unsigned results_checked;

    // Left-to-right square-and-multiply over the full exponent register. A zero
    // exponent gives 1 before any reduction, so it wins even over a zero modulus.
    function bit [MOD_W-1:0] modpow(bit [MOD_W-1:0] b, bit [EXP_MAX_W-1:0] e,
                                    bit [MOD_W-1:0] m);
      bit [63:0] acc;
      acc = 64'd1;
      if (e == '0) return 1;
      if (m == '0) return '0;
      for (int i = EXP_W - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * b) % m;
      end
      return acc[MOD_W-1:0];
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_request(exp_request_t req, bit [MOD_W-1:0] modulus);
      bit [EXP_MAX_W-1:0] e;
      bit [MOD_W-1:0]     predicted;
      // Inverse kind: Fermat exponent modulus - 2, wrapping for moduli below two
      if (req.kind == KIND_INVERSE) begin
        e = {{(EXP_MAX_W-MOD_W){1'b0}}, modulus} - 64'd2;
        inverses_noted++;
      end else begin
        e = req.exponent;
      end
      e &= {EXP_MAX_W{1'b1}} >> (EXP_MAX_W - EXP_W);
      predicted = modpow(req.base, e, modulus);
      expected_powers = {expected_powers, predicted};
      requests_noted++;
    endfunction

    task check_result(logic [MOD_W-1:0] got);
      bit [MOD_W-1:0] want;
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
      end else begin
        want = expected_powers.pop_front();
        results_checked++;
        if (got !== want)
          report_mismatch($sformatf("result %h, predicted %h", got, want));
      end
    endtask

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  // Drive every input to a known value from time zero
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [MOD_W-1:0]     cfg_data    = '0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic                 in_kind     = KIND_POWER;
  logic [MOD_W-1:0]     in_base     = '0;
  logic [EXP_MAX_W-1:0] in_exponent = '0;
  logic                 out_valid;
  logic [MOD_W-1:0]     out_result;

  // Modulus as the block holds it: reset value until the first write
  logic [MOD_W-1:0] cur_modulus = MOD_RESET;
  int unsigned      moduli_used = 1;

  modpow_scoreboard modpow_sb;

  modular_exponentiation_unit #(
    .EXP_BITS(EXP_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take each result on its single valid cycle; the receiver has no way to stall it
  always @(posedge clk) begin
    if (rst_n && out_valid) modpow_sb.check_result(out_result);
  end

  // Present one request and hold it until the block takes it (start high, busy low).
  // Leave start high on return so that back-to-back requests go out with no idle gap.
  task automatic send_request(input logic kind, input logic [MOD_W-1:0] base,
                              input logic [EXP_MAX_W-1:0] exponent);
    exp_request_t req;
    req.kind     = kind;
    req.base     = base;
    req.exponent = exponent;
    start       <= 1'b1;
    in_kind     <= kind;
    in_base     <= base;
    in_exponent <= exponent;
    do @(posedge clk); while (busy);
    modpow_sb.note_request(req, cur_modulus);
  endtask

  // Drop start and hold off until every outstanding request has answered
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (modpow_sb.pending() != 0);
  endtask

  // Write the modulus; call only with the block drained
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_modulus = value;
    moduli_used++;
  endtask

  // Random requests. Keep most exponents short, since run time grows with the
  // exponent's bit length; a few span the full register.
  task automatic run_random_phase(input int unsigned idle_pct);
    logic                 kind;
    logic [MOD_W-1:0]     base;
    logic [EXP_MAX_W-1:0] exponent;
    int unsigned          gap;
    int unsigned          w;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // Idle the sender; an occasional long gap lands deep inside a computation
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        gap = ($urandom_range(9) == 0) ? $urandom_range(2000, 50) : $urandom_range(12, 1);
        repeat (gap) @(posedge clk);
      end
      kind = ($urandom_range(3) == 0) ? KIND_INVERSE : KIND_POWER;
      case ($urandom_range(7))
        0:       base = '0;
        1:       base = '1;
        2:       base = cur_modulus - 1'b1;
        3:       base = cur_modulus;
        default: base = $urandom;
      endcase
      w = $urandom_range(16, 1);
      case ($urandom_range(15))
        0:       exponent = '0;
        1, 2:    exponent = {$urandom, $urandom};
        3:       exponent = 64'd1 << $urandom_range(EXP_W - 1);
        default: exponent = {$urandom, $urandom} >> (EXP_MAX_W - w);
      endcase
      send_request(kind, base, exponent);
      // Now and then, pause until the block has answered everything
      if ($urandom_range(19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    modpow_sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset modulus, a prime
    send_request(KIND_POWER, '0, '0);               // zero exponent
    send_request(KIND_POWER, '1, '0);
    send_request(KIND_POWER, '0, 64'd1);
    send_request(KIND_POWER, 32'd3, 64'd1);         // exponent one: single bit
    send_request(KIND_POWER, 32'd2, 64'd2);         // power-of-two exponent
    send_request(KIND_POWER, 32'd5, 64'h8000_0000_0000_0000);
    send_request(KIND_POWER, '1, '1);               // both fields at their maximum
    send_request(KIND_INVERSE, 32'd3, '1);          // exponent field ignored
    send_request(KIND_INVERSE, '0, '0);
    send_request(KIND_INVERSE, '1, '0);             // base above modulus
    send_request(KIND_POWER, MOD_RESET, 64'd5);     // base equal to modulus
    wait_drained();

    // Smallest legal modulus; the inverse exponent becomes zero
    write_modulus(32'd2);
    send_request(KIND_POWER, 32'd3, 64'd7);
    send_request(KIND_INVERSE, 32'd5, '0);
    wait_drained();

    // Zero modulus: no reduction, zero unless the exponent is zero
    write_modulus('0);
    send_request(KIND_POWER, 32'd7, 64'd3);
    send_request(KIND_POWER, 32'd7, '0);
    send_request(KIND_INVERSE, 32'd7, '0);          // exponent wraps below zero
    wait_drained();

    // Modulus one: zero for every nonzero exponent
    write_modulus(32'd1);
    send_request(KIND_POWER, 32'd5, '0);
    send_request(KIND_POWER, 32'd5, 64'd3);
    send_request(KIND_INVERSE, 32'd9, '0);
    wait_drained();

    // Largest modulus, not prime: inverse kind returns the plain power
    write_modulus('1);
    send_request(KIND_POWER, '1, '1);
    send_request(KIND_INVERSE, 32'd2, '0);
    wait_drained();

    // Largest 32-bit prime
    write_modulus(32'hFFFF_FFFB);
    send_request(KIND_INVERSE, 32'd123456789, '0);
    wait_drained();

    // Random phases, each under its own modulus and sender idling
    write_modulus(32'hFFFF_FFFB);
    run_random_phase(0);
    write_modulus($urandom | 32'h8000_0001);
    run_random_phase(50);
    write_modulus($urandom_range(255, 2));
    run_random_phase(0);
    write_modulus($urandom);
    run_random_phase(33);

    // Allow a full computation's worth of cycles for any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (modpow_sb.pending() != 0)
      modpow_sb.report_mismatch($sformatf("%0d results never arrived", modpow_sb.pending()));

    $display("Run covered %0d requests (%0d inverse) over %0d modulus settings.",
             modpow_sb.requests_noted, modpow_sb.inverses_noted, moduli_used);
    $display("Checked %0d results; %0d mismatches.",
             modpow_sb.results_checked, modpow_sb.mismatches);
    if (modpow_sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run: several times the slowest correct run at the worst-case latency
  initial begin
    #30_000_000;
    $display("Timeout: simulation did not complete");
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_front.sv
rtl/core/mexp_queue.sv
rtl/core/mexp_back.sv
rtl/core/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_test.sv
